// ===== hw/rtl/sha256_pkg.sv =====
// ============================================================================
// SHA-256 package
// Shared types, constants and the rotate helper for the SHA-256 core.
// ============================================================================
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FINISH,
        ST_OUT
    } sha_state_t;

    // controller -> datapath
    typedef struct packed {
        logic       take_byte;   // write input byte into block buffer
        logic       pad_byte;    // write one padding byte at fill position
        logic       pad_mark;    // padding byte is the 0x80 marker
        logic       pad_len;     // block holds the length in its last 8 bytes
        logic       load_vars;   // copy hash words into working vars
        logic       round_en;    // run one round
        logic       add_hash;    // fold working vars into hash words
        logic       clear_len;   // zero the message length
        logic       init_hash;   // reload initial hash values
    } sha_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [6:0] fill;
        logic [5:0] round;
    } sha_status_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] ror32(input logic [31:0] v, input int s);
        ror32 = (v >> s) | (v << (32 - s));
    endfunction

endpackage

// ===== hw/rtl/sha256_byte_stream_hash_core.sv =====
// ============================================================================
// SHA-256 byte stream hash core
// Hashes a byte stream and emits the eight digest words per message.
// ============================================================================
// channel | dir | tdata                  | tuser     | tlast
// s_axis  | in  | data_byte[7:0]         | has_byte  | end_of_message
// m_axis  | out | digest_word[31:0]      | word_number[2:0] | last_word
//
// One byte is taken per cycle while a block fills; the 64th byte of a block
// starts a compression (load, 64 rounds, hash add) on the single round unit.
// The end item adds one pad byte per cycle up to the block end, one or two
// compressions, then eight output items.
// rst_n clears the controller and counters and reloads the initial hash words asynchronously.
// Output stalls hold the digest; input is not taken until output finishes.
module sha256_byte_stream_hash_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_number
    output logic        m_axis_tlast
);
    import sha256_pkg::*;

    sha_cmd_t    cmd;
    sha_status_t status;
    logic [2:0]  sel;

    sha256_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_has    (s_axis_tuser),
        .in_end    (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_sel   (sel),
        .status    (status),
        .cmd       (cmd)
    );

    sha256_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_byte  (s_axis_tdata),
        .out_sel  (sel),
        .status   (status),
        .out_word (m_axis_tdata)
    );

    assign m_axis_tuser = sel;
    assign m_axis_tlast = (sel == 3'd7);

endmodule

// ===== hw/rtl/sha256_datapath.sv =====
// ============================================================================
// SHA-256 datapath
// Block buffer, length counter, rolling schedule, round unit and hash words.
// ============================================================================
module sha256_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sha256_pkg::sha_cmd_t   cmd,
    input  logic [7:0]             in_byte,
    input  logic [2:0]             out_sel,
    output sha256_pkg::sha_status_t status,
    output logic [31:0]            out_word
);
    import sha256_pkg::*;

    logic [31:0] buf_mem [16];   // block buffer, big-endian words
    logic [6:0]  fill_reg;
    logic [60:0] len_reg;
    logic [5:0]  round_reg;
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] h_reg [8];

    logic [7:0]  wr_byte;
    logic [63:0] bits;
    logic [31:0] w_cur, w15, w2, s1, ch, t1, s0, mj;
    logic [3:0]  ri;

    assign bits   = {len_reg, 3'b000};
    assign ri     = round_reg[3:0];
    assign status = '{fill: fill_reg, round: round_reg};
    assign out_word = h_reg[out_sel];

    // write byte: the input byte, or padding: 0x80 marker, zeros, then length in the final eight slots
    always_comb
    begin
        wr_byte = 8'h00;
        if (cmd.take_byte)
            wr_byte = in_byte;
        else if (cmd.pad_mark)
            wr_byte = PAD_BYTE;
        else if (cmd.pad_len && fill_reg[5:3] == 3'b111)
            wr_byte = bits[6'd63 - {fill_reg[2:0], 3'b000} -: 8];
    end

    // round datapath
    always_comb
    begin
        w15 = w_reg[ri + 4'd1];
        w2  = w_reg[ri + 4'd14];
        if (round_reg < 6'd16)
            w_cur = buf_mem[ri];
        else
            w_cur = w_reg[ri] + (ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3))
                  + w_reg[ri + 4'd9] + (ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10));
        s1 = ror32(v_reg[4], 6) ^ ror32(v_reg[4], 11) ^ ror32(v_reg[4], 25);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + s1 + ch + ROUND_K[round_reg] + w_cur;
        s0 = ror32(v_reg[0], 2) ^ ror32(v_reg[0], 13) ^ ror32(v_reg[0], 22);
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    end

    // block buffer write port, one byte lane per item
    always_ff @(posedge clk)
    begin
        if (cmd.take_byte || cmd.pad_byte)
            buf_mem[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= wr_byte;
    end

    // schedule and working variables
    always_ff @(posedge clk)
    begin
        if (cmd.load_vars)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
        end
        else if (cmd.round_en)
        begin
            w_reg[ri] <= w_cur;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + s0 + mj;
        end
    end

    // control counters and hash words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            len_reg   <= '0;
            round_reg <= '0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= INIT_HASH[i];
        end
        else
        begin
            if (cmd.clear_len)
                len_reg <= '0;
            else if (cmd.take_byte)
                len_reg <= len_reg + 61'd1;
            if (cmd.add_hash)
                fill_reg <= '0;
            else if (cmd.take_byte || cmd.pad_byte)
                fill_reg <= fill_reg + 7'd1;
            if (cmd.load_vars)
                round_reg <= '0;
            else if (cmd.round_en)
                round_reg <= round_reg + 6'd1;
            if (cmd.add_hash)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
            end
            else if (cmd.init_hash)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= INIT_HASH[i];
            end
        end
    end

endmodule

// ===== hw/rtl/sha256_ctrl.sv =====
// ============================================================================
// SHA-256 controller
// Sequences byte intake, padding, compression and digest output.
// ============================================================================
module sha256_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    in_has,
    input  logic                    in_end,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [2:0]              out_sel,
    input  sha256_pkg::sha_status_t status,
    output sha256_pkg::sha_cmd_t    cmd
);
    import sha256_pkg::*;

    sha_state_t state_reg, state_next;
    logic       final_reg, final_next;   // block holds the length field
    logic       fin_pend_reg, fin_pend_next; // end item seen, padding pending
    logic       mark_reg, mark_next;     // 0x80 marker already written
    logic [2:0] sel_reg, sel_next;
    logic       acc;

    assign out_sel   = sel_reg;
    assign acc       = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            final_reg    <= 1'b0;
            fin_pend_reg <= 1'b0;
            mark_reg     <= 1'b0;
            sel_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            final_reg    <= final_next;
            fin_pend_reg <= fin_pend_next;
            mark_reg     <= mark_next;
            sel_reg      <= sel_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        final_next    = final_reg;
        fin_pend_next = fin_pend_reg;
        mark_next     = mark_reg;
        sel_next      = sel_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (acc)
                begin
                    cmd.take_byte = in_has;
                    fin_pend_next = in_end;
                    mark_next     = 1'b0;
                    if (in_has && status.fill == 7'd63)
                    begin
                        final_next = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else if (in_end)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                // 0x80 marker, zeros, length; a marker past byte 55 leaves no
                // room for the length, so that block is compressed first
                cmd.pad_byte = 1'b1;
                if (!mark_reg)
                begin
                    cmd.pad_mark = 1'b1;
                    mark_next    = 1'b1;
                    final_next   = (status.fill < 7'd56);
                end
                else
                    cmd.pad_len = final_reg;
                if (status.fill == 7'd63)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.load_vars = 1'b1;
                state_next    = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                if (status.round == 6'd63)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.add_hash = 1'b1;
                if (final_reg)
                begin
                    cmd.clear_len = 1'b1;
                    sel_next      = '0;
                    state_next    = ST_OUT;
                end
                else if (fin_pend_reg)
                begin
                    final_next = 1'b1;
                    state_next = ST_PAD;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    sel_next = sel_reg + 3'd1;
                    if (sel_reg == 3'd7)
                    begin
                        cmd.init_hash = 1'b1;
                        fin_pend_next = 1'b0;
                        final_next    = 1'b0;
                        mark_next     = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == ST_OUT)
        else $error("output valid outside output state");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_byte |-> in_ready)
        else $error("byte taken while not ready");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && status.round == 6'd63) |=> state_reg == ST_FINISH)
        else $error("round count overrun");

endmodule
